// ===== hw/rtl/miller_rabin_prime_test_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Miller-Rabin round engine
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_TOP_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_TOP_DEFINES_SVH

// implication checked every cycle outside reset
`define MRPT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication outside reset
`define MRPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mrpt_pkg.sv =====
// ---------------------------------------------------------------------------
// Miller-Rabin package
// Constants and sequencer state type.
// ---------------------------------------------------------------------------
package mrpt_pkg;

   localparam int DefWidth = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SPLIT,
      ST_EXP_SEL,
      ST_MUL,
      ST_EXP_NEXT,
      ST_CHECK,
      ST_SQ_SEL,
      ST_SQ_CHECK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_X_BASE,
      MUL_BASE_BASE,
      MUL_X_X
   } mul_op_type;

endpackage

// ===== hw/rtl/miller_rabin_prime_test_top.sv =====
// ---------------------------------------------------------------------------
// Miller-Rabin round engine
// One witness round per item over a single shift-and-add modular unit.
// ---------------------------------------------------------------------------
// Each item runs one Miller-Rabin round on a shared modular unit that
// handles one bit per cycle. The witness is first reduced modulo n
// (restoring, one bit a cycle), then n-1 is split, and each exponent bit
// takes a select step and its modular products, followed by the further
// squarings. Candidates below four or even finish without a reduction,
// trivial witnesses right after it.
// The block takes one item at a time; the result sits in an output register
// until taken, and a new result waits while that register is still full.
`include "miller_rabin_prime_test_top_defines.svh"

module miller_rabin_prime_test_top #(
   parameter int WIDTH = mrpt_pkg::DefWidth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [WIDTH-1:0] req_candidate,
   input  logic [WIDTH-1:0] req_witness,
   input  logic             req_last_round,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_round_passed,
   output logic             rsp_probable_prime,
   output logic             rsp_final_res
);

   localparam int CW = $clog2(WIDTH + 1);

   mrpt_pkg::state_type  state_ff, state_in;
   mrpt_pkg::mul_op_type op_ff, op_in;

   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] x_ff, x_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] mx_ff, mx_in;
   logic [WIDTH-1:0] my_ff, my_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    r_ff, r_in;
   logic             last_ff, last_in;
   logic             verdict_ff, verdict_in;
   logic             pass_ff, pass_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pass_ff, rsp_pass_in;
   logic             rsp_prime_ff, rsp_prime_in;
   logic             rsp_final_ff, rsp_final_in;

   logic [WIDTH:0]   dbl, dbl_red, sum, sum_red, rsh;
   logic [WIDTH-1:0] nm1, step;
   logic             finish;

   assign nm1 = n_ff - {{(WIDTH-1){1'b0}}, 1'b1};

   // shared unit: one shift-and-add modular step
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, n_ff}) ? dbl - {1'b0, n_ff} : dbl;
      sum     = dbl_red + (my_ff[WIDTH-1] ? {1'b0, mx_ff} : '0);
      sum_red = (sum >= {1'b0, n_ff}) ? sum - {1'b0, n_ff} : sum;
      step    = sum_red[WIDTH-1:0];
      rsh     = {rem_ff[WIDTH-1:0], a_ff[WIDTH-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrpt_pkg::ST_IDLE;
         verdict_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         verdict_ff   <= verdict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      n_ff         <= n_in;
      a_ff         <= a_in;
      x_ff         <= x_in;
      d_ff         <= d_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      cnt_ff       <= cnt_in;
      r_ff         <= r_in;
      last_ff      <= last_in;
      pass_ff      <= pass_in;
      rsp_pass_ff  <= rsp_pass_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      x_in         = x_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      cnt_in       = cnt_ff;
      r_in         = r_ff;
      last_in      = last_ff;
      verdict_in   = verdict_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pass_in  = rsp_pass_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_final_in = rsp_final_ff;
      finish       = 1'b0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mrpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in    = req_candidate;
               a_in    = req_witness;
               last_in = req_last_round;
               rem_in  = '0;
               cnt_in  = '0;
               if (req_candidate < WIDTH'(2)) begin
                  pass_in  = 1'b0;
                  state_in = mrpt_pkg::ST_DONE;
               end else if (req_candidate == WIDTH'(2) || req_candidate == WIDTH'(3)) begin
                  pass_in  = 1'b1;
                  state_in = mrpt_pkg::ST_DONE;
               end else if (!req_candidate[0]) begin
                  pass_in  = 1'b0;
                  state_in = mrpt_pkg::ST_DONE;
               end else begin
                  state_in = mrpt_pkg::ST_REDUCE;
               end
            end
         end
         // restoring reduction of the witness, one bit a cycle
         mrpt_pkg::ST_REDUCE: begin
            rem_in = (rsh >= {1'b0, n_ff}) ? rsh - {1'b0, n_ff} : rsh;
            a_in   = {a_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WIDTH - 1)) begin
               d_in   = nm1;
               r_in   = '0;
               state_in = mrpt_pkg::ST_SPLIT;
            end
         end
         mrpt_pkg::ST_SPLIT: begin
            a_in = rem_ff[WIDTH-1:0];
            if (rem_ff[WIDTH-1:0] == '0 || rem_ff[WIDTH-1:0] == WIDTH'(1)
                || rem_ff[WIDTH-1:0] == nm1) begin
               pass_in  = 1'b1;
               state_in = mrpt_pkg::ST_DONE;
            end else if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               r_in = r_ff + CW'(1);
            end else begin
               x_in     = WIDTH'(1);
               state_in = mrpt_pkg::ST_EXP_SEL;
            end
         end
         mrpt_pkg::ST_EXP_SEL: begin
            acc_in = '0;
            cnt_in = '0;
            if (d_ff == '0) begin
               state_in = mrpt_pkg::ST_CHECK;
            end else if (d_ff[0]) begin
               op_in = mrpt_pkg::MUL_X_BASE;
               mx_in = x_ff;
               my_in = a_ff;
               state_in = mrpt_pkg::ST_MUL;
            end else begin
               op_in = mrpt_pkg::MUL_BASE_BASE;
               mx_in = a_ff;
               my_in = a_ff;
               state_in = mrpt_pkg::ST_MUL;
            end
         end
         mrpt_pkg::ST_MUL: begin
            acc_in = step;
            my_in  = {my_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WIDTH - 1)) begin
               state_in = mrpt_pkg::ST_EXP_NEXT;
            end
         end
         mrpt_pkg::ST_EXP_NEXT: begin
            acc_in = '0;
            cnt_in = '0;
            case (op_ff)
               mrpt_pkg::MUL_X_BASE: begin
                  x_in  = acc_ff;
                  op_in = mrpt_pkg::MUL_BASE_BASE;
                  mx_in = a_ff;
                  my_in = a_ff;
                  state_in = mrpt_pkg::ST_MUL;
               end
               mrpt_pkg::MUL_BASE_BASE: begin
                  a_in = acc_ff;
                  d_in = d_ff >> 1;
                  state_in = mrpt_pkg::ST_EXP_SEL;
               end
               default: begin
                  x_in     = acc_ff;
                  state_in = mrpt_pkg::ST_SQ_CHECK;
               end
            endcase
         end
         mrpt_pkg::ST_CHECK: begin
            cnt_in = CW'(1);
            if (x_ff == WIDTH'(1) || x_ff == nm1) begin
               pass_in  = 1'b1;
               state_in = mrpt_pkg::ST_DONE;
            end else begin
               state_in = mrpt_pkg::ST_SQ_SEL;
            end
         end
         mrpt_pkg::ST_SQ_SEL: begin
            if (cnt_ff >= r_ff) begin
               pass_in  = 1'b0;
               state_in = mrpt_pkg::ST_DONE;
            end else begin
               r_in   = r_ff - CW'(1);
               acc_in = '0;
               cnt_in = '0;
               op_in  = mrpt_pkg::MUL_X_X;
               mx_in  = x_ff;
               my_in  = x_ff;
               state_in = mrpt_pkg::ST_MUL;
            end
         end
         mrpt_pkg::ST_SQ_CHECK: begin
            cnt_in = CW'(1);
            if (x_ff == nm1) begin
               pass_in  = 1'b1;
               state_in = mrpt_pkg::ST_DONE;
            end else if (x_ff == WIDTH'(1)) begin
               pass_in  = 1'b0;
               state_in = mrpt_pkg::ST_DONE;
            end else begin
               state_in = mrpt_pkg::ST_SQ_SEL;
            end
         end
         mrpt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_pass_in  = pass_ff;
               rsp_prime_in = verdict_ff & pass_ff;
               rsp_final_in = last_ff;
               verdict_in   = last_ff ? 1'b1 : (verdict_ff & pass_ff);
               state_in     = mrpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrpt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_round_passed   = rsp_pass_ff;
   assign rsp_probable_prime = rsp_prime_ff;
   assign rsp_final_res      = rsp_final_ff;

   `MRPT_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == mrpt_pkg::ST_IDLE,
      "ready outside idle")
   `MRPT_ASSERT_NEXT(a_finish_valid, clock, reset, finish, rsp_valid,
      "finished item not presented")
   `MRPT_ASSERT_IMP(a_prime_implies_pass, clock, reset, rsp_valid && rsp_probable_prime,
      rsp_round_passed, "probable prime without round pass")
   `MRPT_ASSERT_NEXT(a_verdict_reset, clock, reset, finish && last_ff, verdict_ff,
      "running verdict not restored after final round")

endmodule
